/* sv/rhsd_pkg.sv */
// Shared types, constants and pixel arithmetic for the RGBA half-scale downsampler.
`timescale 1ns / 1ps

package rhsd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int PIXEL_BYTES = 4;
    localparam int PIX_W       = PIXEL_BYTES * 8;
    localparam int POS_W       = 12;
    localparam int DIM_W       = 13;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_DECIMATE = 1'b0;
    localparam logic MODE_BOX      = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN        = 13'd2;
    localparam logic [DIM_W-1:0] RESET_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT   = 13'd480;
    localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

    typedef logic [PIX_W-1:0] t_pixel;

    // Per-step decision made at the moment an input pixel is accepted.
    typedef struct packed {
        logic                is_left;   // even column inside the used area
        logic                wr_store;  // odd column of an even row
        logic                rd_store;  // odd column of an odd row: a result follows
        logic                last;      // final result of the frame
        logic [STORE_AW-1:0] idx;
    } t_step;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Truncating average of each byte lane.
    function automatic t_pixel avg_pixel(input t_pixel a, input t_pixel b);
        t_pixel r;
        logic [8:0] s;
        r = '0;
        for (int k = 0; k < PIXEL_BYTES; k++) begin
            s = {1'b0, a[k*8 +: 8]} + {1'b0, b[k*8 +: 8]};
            r[k*8 +: 8] = s[8:1];
        end
        return r;
    endfunction

endpackage

/* sv/rhsd_line_store.sv */
// Single-port-write, registered-read memory holding the pair values of one row.
`timescale 1ns / 1ps

module rhsd_line_store #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rhsd_pos_ctrl.sv */
// Column and row tracking and the per-pixel decision of what the step does.
`timescale 1ns / 1ps

module rhsd_pos_ctrl import rhsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output t_step            o_step
);

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] w_col_ext, w_row_ext;
    logic [DIM_W-1:0] w_col_inc, w_row_inc;
    logic [DIM_W-1:0] w_used_w, w_used_h;
    logic             w_inside;

    assign w_col_ext = {1'b0, r_col};
    assign w_row_ext = {1'b0, r_row};
    assign w_col_inc = w_col_ext + 13'd1;
    assign w_row_inc = w_row_ext + 13'd1;
    assign w_used_w  = {i_width[DIM_W-1:1], 1'b0};
    assign w_used_h  = {i_height[DIM_W-1:1], 1'b0};
    assign w_inside  = (w_col_ext < w_used_w) && (w_row_ext < w_used_h);

    always_comb begin
        o_step.is_left  = w_inside && !r_col[0];
        o_step.wr_store = w_inside && r_col[0] && !r_row[0];
        o_step.rd_store = w_inside && r_col[0] && r_row[0];
        o_step.last     = (w_col_inc == w_used_w) && (w_row_inc == w_used_h);
        o_step.idx      = r_col[POS_W-1:1];
    end

    // A position at or past a bound wraps at the end of its step, which also
    // covers a geometry that shrank under a frame in progress.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_inc >= i_width) begin
            n_col = '0;
            n_row = (w_row_inc >= i_height) ? '0 : w_row_inc[POS_W-1:0];
        end else begin
            n_col = w_col_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* sv/rgba_half_scale_downsampler_unit.sv */
// Top level of the RGBA half-scale downsampler: config registers, pipeline and output.
`timescale 1ns / 1ps

// Usage: RGBA pixels arrive in raster order on the s_axis request channel, one per
// accepted request, red in the lowest byte. Downsampled pixels leave on m_axis;
// tlast marks the final output pixel of a frame. Output size is floor(width/2) by
// floor(height/2); an odd last column or row is consumed and dropped.
// One pixel per clock is accepted in steady state while the receiver keeps up.
// The result for the pixel on the odd column of an odd row passes the line store read,
// registered together with stage one, and then the output register before it reaches m_axis.
// The line store is one memory with one write and one registered read per cycle;
// even rows write pair values, odd rows read them back.
// When the receiver stalls, the output register holds its pixel and a second stage
// keeps taking requests until it holds a result; s_axis stalls only when both are full.
// Reset clears positions, pipeline valids and loads mode box, 640 by 480.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// width and height are clamped to 2..4096 when written.
module rgba_half_scale_downsampler_unit import rhsd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input pixel stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [PIX_W-1:0]     i_s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    // Output pixel stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [PIX_W-1:0]     o_m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                 o_m_axis_tlast,   // frame_done
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic             r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BOX;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= clamp_dim(i_cfg_data, MAX_WIDTH_DIM);
                CFG_HEIGHT: r_height <= clamp_dim(i_cfg_data, MAX_HEIGHT_DIM);
                default: ;
            endcase
        end
    end

    logic   w_out_en;
    logic   w_s1_en;
    logic   w_accept;
    t_step  w_step;
    t_pixel w_pair;
    t_pixel w_rd_data;
    t_pixel w_result;

    logic   r_s1_valid;
    logic   r_s1_mode;
    logic   r_s1_last;
    t_pixel r_s1_pair;
    t_pixel r_pending;
    logic   r_out_valid;
    logic   r_out_last;
    t_pixel r_out_data;

    assign w_out_en        = !r_out_valid || i_m_axis_tready;
    assign w_s1_en         = w_out_en || !r_s1_valid;
    assign o_s_axis_tready = w_s1_en;
    assign w_accept        = i_s_axis_tvalid && w_s1_en;

    rhsd_pos_ctrl u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_width  (r_width),
        .i_height (r_height),
        .o_step   (w_step)
    );

    assign w_pair = (r_mode == MODE_BOX) ? avg_pixel(r_pending, i_s_axis_tdata) : r_pending;

    // The read data register only moves together with stage one, so a stalled
    // result keeps the stored value it was paired with.
    rhsd_line_store #(
        .ADDR_W (STORE_AW),
        .DATA_W (PIX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_step.wr_store),
        .i_waddr (w_step.idx),
        .i_wdata (w_pair),
        .i_re    (w_s1_en),
        .i_raddr (w_step.idx),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_accept && w_step.is_left) begin
            r_pending <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= w_accept && w_step.rd_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_mode <= r_mode;
            r_s1_last <= w_step.last;
            r_s1_pair <= w_pair;
        end
    end

    assign w_result = (r_s1_mode == MODE_BOX) ? avg_pixel(w_rd_data, r_s1_pair) : w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_data <= w_result;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
